@@ rtl/core/pid_pkg.sv @@
package pid_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int MAX_BPP       = 16;
	localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_COLOR  = CFG_IDX_W'(1);

	localparam logic [31:0] ARGB_BLACK = 32'hFF00_0000;

	typedef struct packed {
		logic restart;
		logic hdr_byte;
		logic pal_byte;
		logic pix_byte;
		logic cnt_clear;
		logic issue_pix;
		logic issue_err;
		logic last;
	} pid_cmd_t;

	typedef struct packed {
		logic hdr_last;
		logic bpp_bad;
		logic cc_zero_next;
		logic total_nz;
		logic pal_last;
		logic pix_more;
		logic pix_more_after;
		logic done_after_full;
		logic done_full;
		logic adv;
	} pid_status_t;

endpackage

@@ rtl/core/palette_image_decoder_core.sv @@
// Header and palette bytes are each accepted in the idle state; a pixel byte is accepted,
// then yields its pixel indices in the pixel state before the next byte is taken.
// After index extraction a pixel passes the palette RAM read, then the output register;
// the single palette read port sets one pixel per cycle when the output does not stall.
// Asynchronous active-low reset clears control state, header fields and config;
// palette RAM contents are not cleared and need no clearing pass.
module palette_image_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          start_of_file,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue,
	output logic [7:0]                    alpha,
	output logic                          in_range,
	output logic                          last_pixel,
	output logic                          header_error,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pid_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import pid_pkg::*;

	pid_cmd_t    cmd;
	pid_status_t sts;

	assign cfg_ready = 1'b1;

	pid_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.start_of_file(start_of_file),
		.sts          (sts),
		.cmd          (cmd)
	);

	pid_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (data_byte),
		.start_of_file(start_of_file),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.in_range     (in_range),
		.last_pixel   (last_pixel),
		.header_error (header_error)
	);

endmodule

@@ rtl/core/pid_ram.sv @@
module pid_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/pid_ctrl.sv @@
module pid_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 start_of_file,
	input  pid_pkg::pid_status_t sts,
	output pid_pkg::pid_cmd_t    cmd
);
	import pid_pkg::*;

	typedef enum logic [2:0] {
		P_HEADER,
		P_PALETTE,
		P_PIXELS,
		P_DONE,
		P_ERROR
	} phase_t;

	typedef enum logic {
		S_IDLE,
		S_PIX
	} state_t;

	phase_t phase_q, phase_d, ph;
	state_t state_q, state_d;
	logic   accept;

	assign in_stall = (state_q != S_IDLE) || !sts.adv;
	assign accept   = in_valid && !in_stall;
	assign ph       = start_of_file ? P_HEADER : phase_q;

	always_comb begin
		cmd     = '0;
		phase_d = phase_q;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.restart = start_of_file;
					phase_d     = ph;
					case (ph)
						P_HEADER: begin
							cmd.hdr_byte = 1'b1;
							if (sts.hdr_last) begin
								cmd.cnt_clear = 1'b1;
								if (sts.bpp_bad) begin
									cmd.issue_err = 1'b1;
									cmd.last      = 1'b1;
									phase_d       = P_ERROR;
								end else if (!sts.cc_zero_next) begin
									phase_d = P_PALETTE;
								end else if (sts.total_nz) begin
									phase_d = P_PIXELS;
								end else begin
									phase_d = P_DONE;
								end
							end
						end
						P_PALETTE: begin
							cmd.pal_byte = 1'b1;
							if (sts.pal_last) begin
								cmd.cnt_clear = 1'b1;
								phase_d       = sts.total_nz ? P_PIXELS : P_DONE;
							end
						end
						P_PIXELS: begin
							cmd.pix_byte = 1'b1;
							state_d      = S_PIX;
						end
						default: begin
						end
					endcase
				end
			end
			S_PIX: begin
				if (sts.pix_more) begin
					if (sts.adv) begin
						cmd.issue_pix = 1'b1;
						cmd.last      = !sts.pix_more_after;
						if (!sts.pix_more_after) begin
							state_d = S_IDLE;
							if (sts.done_after_full) begin
								phase_d = P_DONE;
							end
						end
					end
				end else begin
					state_d = S_IDLE;
					if (sts.done_full) begin
						phase_d = P_DONE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_HEADER;
			state_q <= S_IDLE;
		end else begin
			phase_q <= phase_d;
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/pid_datapath.sv @@
module pid_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [7:0]                     data_byte,
	input  logic                           start_of_file,
	input  pid_pkg::pid_cmd_t              cmd,
	output pid_pkg::pid_status_t           sts,
	input  logic                           cfg_valid,
	input  logic [pid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue,
	output logic [7:0]                     alpha,
	output logic                           in_range,
	output logic                           last_pixel,
	output logic                           header_error
);
	import pid_pkg::*;

	logic [17:0] cnt_q, eff_cnt;
	logic [15:0] w_q, h_q, cc_q;
	logic [7:0]  bpp_q;
	logic [31:0] total_q;
	logic [23:0] word_q;
	logic [23:0] buf_q;
	logic [4:0]  bc_q, bpp5, sh, bc_after;
	logic [31:0] done_q, done_p1;
	logic [23:0] mask;
	logic [15:0] idx;
	logic        idx_inr;
	logic        ovr_en_q;
	logic [31:0] ovr_color_q;

	logic        pal_we;
	logic [31:0] rd_data;

	logic        v_s1, inr_s1, zero_s1, err_s1, last_s1;
	logic        out_take;
	logic [31:0] argb;

	assign eff_cnt  = start_of_file ? '0 : cnt_q;
	assign bpp5     = bpp_q[4:0];
	assign sh       = bc_q - bpp5;
	assign bc_after = bc_q - bpp5;
	assign done_p1  = done_q + 32'd1;
	assign mask     = (24'd1 << bpp5) - 24'd1;
	assign idx      = 16'((buf_q >> sh) & mask);
	assign idx_inr  = ({1'b0, idx} < 17'(PALETTE_DEPTH)) && (idx < cc_q);

	assign out_take = !out_valid || !out_stall;

	always_comb begin
		sts                 = '0;
		sts.hdr_last        = (eff_cnt == 18'd6);
		sts.bpp_bad         = (bpp_q == 8'd0) || (bpp_q > 8'(MAX_BPP));
		sts.cc_zero_next    = ({cc_q[15:8], data_byte} == 16'd0);
		sts.total_nz        = (total_q != 32'd0);
		sts.pal_last        = ((eff_cnt + 18'd1) == {cc_q, 2'b00});
		sts.pix_more        = (bc_q >= bpp5) && (done_q < total_q);
		sts.pix_more_after  = (bc_after >= bpp5) && (done_p1 < total_q);
		sts.done_after_full = (done_p1 >= total_q);
		sts.done_full       = (done_q >= total_q);
		sts.adv             = !v_s1 || out_take;
	end

	assign pal_we = cmd.pal_byte && (eff_cnt[1:0] == 2'd3)
		&& ({1'b0, eff_cnt[17:2]} < 17'(PALETTE_DEPTH));

	pid_ram #(
		.WIDTH(32),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (pal_we),
		.waddr(eff_cnt[PAL_AW+1:2]),
		.wdata({word_q, data_byte}),
		.re   (cmd.issue_pix),
		.raddr(idx[PAL_AW-1:0]),
		.rdata(rd_data)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovr_en_q    <= 1'b0;
			ovr_color_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OVERRIDE_ENABLE: ovr_en_q    <= cfg_data[0];
				REG_OVERRIDE_COLOR:  ovr_color_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// header, palette and bit stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			w_q     <= '0;
			h_q     <= '0;
			bpp_q   <= '0;
			cc_q    <= '0;
			total_q <= '0;
			buf_q   <= '0;
			bc_q    <= '0;
			done_q  <= '0;
		end else begin
			total_q <= w_q * h_q;
			if (cmd.cnt_clear) begin
				cnt_q <= '0;
			end else if (cmd.hdr_byte || cmd.pal_byte) begin
				cnt_q <= eff_cnt + 18'd1;
			end
			if (cmd.hdr_byte) begin
				case (eff_cnt[2:0])
					3'd0: w_q[15:8]  <= data_byte;
					3'd1: w_q[7:0]   <= data_byte;
					3'd2: h_q[15:8]  <= data_byte;
					3'd3: h_q[7:0]   <= data_byte;
					3'd4: bpp_q      <= data_byte;
					3'd5: cc_q[15:8] <= data_byte;
					default: cc_q[7:0] <= data_byte;
				endcase
			end
			if (cmd.restart) begin
				buf_q  <= '0;
				bc_q   <= '0;
				done_q <= '0;
			end else if (cmd.pix_byte) begin
				buf_q <= {buf_q[15:0], data_byte};
				bc_q  <= bc_q + 5'd8;
			end else if (cmd.issue_pix) begin
				bc_q   <= bc_after;
				done_q <= done_p1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pal_byte) begin
			word_q <= {word_q[15:0], data_byte};
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.issue_pix || cmd.issue_err) begin
			v_s1 <= 1'b1;
		end else if (out_take) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue_pix || cmd.issue_err) begin
			inr_s1  <= cmd.issue_pix && idx_inr;
			zero_s1 <= (idx == 16'd0);
			err_s1  <= cmd.issue_err;
			last_s1 <= cmd.last;
		end
	end

	always_comb begin
		if (err_s1) begin
			argb = '0;
		end else if (!inr_s1) begin
			argb = ARGB_BLACK;
		end else if (ovr_en_q && zero_s1) begin
			argb = ovr_color_q;
		end else begin
			argb = rd_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (v_s1 && out_take) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && out_take) begin
			alpha        <= argb[31:24];
			red          <= argb[23:16];
			green        <= argb[15:8];
			blue         <= argb[7:0];
			in_range     <= inr_s1;
			last_pixel   <= last_s1;
			header_error <= err_s1;
		end
	end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

class rgba_scoreboard;
	typedef enum logic [2:0] {
		HDR_PHASE, PAL_PHASE, PIX_PHASE, FIN_PHASE, BAD_PHASE
	} phase_t;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       in_range;
		logic       last_pixel;
		logic       header_error;
	} rgba_t;

	rgba_t       pixels_due[$];
	int          errors;

	bit          ovr_en;
	logic [31:0] ovr_color;

	phase_t      phase;
	logic [19:0] byte_cnt;
	logic [15:0] width;
	logic [15:0] height;
	logic [7:0]  bpp;
	logic [15:0] ncolors;
	logic [31:0] palette [pid_pkg::PALETTE_DEPTH];
	logic [23:0] bitbuf;
	int          nbits;
	logic [31:0] done_pix;

	function new();
		errors    = 0;
		ovr_en    = 0;
		ovr_color = '0;
		phase     = HDR_PHASE;
		byte_cnt  = '0;
		width     = '0;
		height    = '0;
		bpp       = '0;
		ncolors   = '0;
		bitbuf    = '0;
		nbits     = 0;
		done_pix  = '0;
		foreach (palette[i]) palette[i] = '0;
	endfunction

	function int pending();
		return pixels_due.size();
	endfunction

	function void set_reg(logic [pid_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
		case (idx)
			pid_pkg::REG_OVERRIDE_ENABLE: ovr_en = d[0];
			pid_pkg::REG_OVERRIDE_COLOR:  ovr_color = d;
			default: ;
		endcase
	endfunction

	function void push_pixel(logic [31:0] argb, bit inr, bit err);
		rgba_t p;
		p.red          = argb[23:16];
		p.green        = argb[15:8];
		p.blue         = argb[7:0];
		p.alpha        = argb[31:24];
		p.in_range     = inr;
		p.last_pixel   = 1'b0;
		p.header_error = err;
		pixels_due     = {pixels_due, p};
	endfunction

	function void next_phase_after_header();
		byte_cnt = '0;
		if (ncolors != 0)
			phase = PAL_PHASE;
		else if (32'(width) * 32'(height) != 0)
			phase = PIX_PHASE;
		else
			phase = FIN_PHASE;
	endfunction

	// one accepted byte of the file stream
	function void take_byte(logic [7:0] b, logic sof);
		int          n;
		int          entry;
		int          lane;
		int          lim;
		logic [31:0] total;
		logic [31:0] mask;
		logic [31:0] idx;
		logic [31:0] argb;
		bit          inr;
		n = 0;
		if (sof) begin
			phase    = HDR_PHASE;
			byte_cnt = '0;
			bitbuf   = '0;
			nbits    = 0;
			done_pix = '0;
		end
		case (phase)
			HDR_PHASE: begin
				case (byte_cnt)
					0: width = {b, 8'h00};
					1: width[7:0] = b;
					2: height = {b, 8'h00};
					3: height[7:0] = b;
					4: bpp = b;
					5: ncolors = {b, 8'h00};
					default: ncolors[7:0] = ncolors[7:0] | b;
				endcase
				byte_cnt = byte_cnt + 1'b1;
				if (byte_cnt >= 7) begin
					if (bpp == 0 || bpp > pid_pkg::MAX_BPP) begin
						phase    = BAD_PHASE;
						byte_cnt = '0;
						push_pixel('0, 1'b0, 1'b1);
						n = 1;
					end else begin
						next_phase_after_header();
					end
				end
			end
			PAL_PHASE: begin
				entry = int'(byte_cnt >> 2);
				lane  = int'(byte_cnt[1:0]);
				if (entry < pid_pkg::PALETTE_DEPTH)
					palette[entry][(3 - lane) * 8 +: 8] = b;
				byte_cnt = byte_cnt + 1'b1;
				if (32'(byte_cnt) >= 32'(ncolors) * 4) begin
					byte_cnt = '0;
					phase = (32'(width) * 32'(height) != 0) ? PIX_PHASE : FIN_PHASE;
				end
			end
			PIX_PHASE: begin
				total  = 32'(width) * 32'(height);
				lim    = (ncolors > pid_pkg::PALETTE_DEPTH) ? pid_pkg::PALETTE_DEPTH
					: int'(ncolors);
				mask   = (32'd1 << bpp) - 1;
				bitbuf = {bitbuf[15:0], b};
				nbits  = nbits + 8;
				while (nbits >= int'(bpp) && done_pix < total && n < 8) begin
					idx   = ({8'h00, bitbuf} >> (nbits - int'(bpp))) & mask;
					nbits = nbits - int'(bpp);
					argb  = pid_pkg::ARGB_BLACK;
					inr   = 0;
					if (idx < 32'(lim)) begin
						inr  = 1;
						argb = (idx == 0 && ovr_en) ? ovr_color : palette[idx];
					end
					push_pixel(argb, inr, 1'b0);
					n++;
					done_pix++;
				end
				if (done_pix >= total)
					phase = FIN_PHASE;
			end
			default: ;
		endcase
		if (n > 0)
			pixels_due[pixels_due.size() - 1].last_pixel = 1'b1;
	endfunction

	function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endfunction

	function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] bl, logic [7:0] a,
			logic inr, logic last, logic err);
		rgba_t p;
		if (pixels_due.size() == 0) begin
			$error("unexpected pixel transfer with nothing expected");
			errors++;
			return;
		end
		p = pixels_due.pop_front();
		cmp_field("red", p.red, r);
		cmp_field("green", p.green, g);
		cmp_field("blue", p.blue, bl);
		cmp_field("alpha", p.alpha, a);
		cmp_field("in_range", 8'(p.in_range), 8'(inr));
		cmp_field("last_pixel", 8'(p.last_pixel), 8'(last));
		cmp_field("header_error", 8'(p.header_error), 8'(err));
	endfunction
endclass

module testbench;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN       = 24;
	localparam int LIMIT       = 4000;
	localparam int RAND_BYTES  = 30;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [7:0]                    data_byte = '0;
	logic                          start_of_file = 1'b0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [7:0]                    red;
	logic [7:0]                    green;
	logic [7:0]                    blue;
	logic [7:0]                    alpha;
	logic                          in_range;
	logic                          last_pixel;
	logic                          header_error;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [pid_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                   cfg_data = '0;

	rgba_scoreboard sb;
	logic [7:0]     file_q[$];
	bit             calm = 0;
	int             hold_asked = 0;
	int             hold_served = 0;
	int             hold_left = 0;
	int             quiet = 0;
	int             rand_sent = 0;

	palette_image_decoder_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.in_range      (in_range),
		.last_pixel    (last_pixel),
		.header_error  (header_error),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// transfer monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.take_byte(data_byte, start_of_file);
			if (out_valid && !out_stall)
				sb.check_pixel(red, green, blue, alpha, in_range, last_pixel, header_error);
		end
	end

	// output back-pressure
	always @(posedge clk) begin
		if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 37);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic put_byte(input logic [7:0] d, input logic sof);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= d;
		start_of_file <= sof;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_file();
		foreach (file_q[i]) put_byte(file_q[i], i == 0);
	endtask

	// stop sending and wait for every pixel to come out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_override(input bit en, input logic [31:0] color);
		cfg_valid <= 1'b1;
		cfg_index <= pid_pkg::REG_OVERRIDE_ENABLE;
		cfg_data  <= {31'b0, en};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= pid_pkg::REG_OVERRIDE_COLOR;
		cfg_data  <= color;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic start_file(input logic [15:0] w, input logic [15:0] h,
			input logic [7:0] bpp, input logic [15:0] ncol);
		file_q = {w[15:8], w[7:0], h[15:8], h[7:0], bpp, ncol[15:8], ncol[7:0]};
	endtask

	task automatic add_random(input int n);
		repeat (n) file_q = {file_q, 8'($urandom)};
	endtask

	task automatic random_file(input int kind);
		int          w;
		int          h;
		int          bpp;
		int          ncol;
		int          cut;
		if (kind == 0) begin
			// bad depth, then bytes that must be ignored
			bpp = $urandom_range(1) ? 0 : $urandom_range(pid_pkg::MAX_BPP + 1, 255);
			start_file(16'($urandom), 16'($urandom), 8'(bpp), 16'($urandom));
			add_random($urandom_range(1, 3));
		end else begin
			bpp  = $urandom_range(3) != 0 ? (1 << $urandom_range(3))
				: $urandom_range(1, pid_pkg::MAX_BPP);
			ncol = $urandom_range(9) == 0 ? 0 : $urandom_range(1, 6);
			w    = $urandom_range(9) == 0 ? 0 : $urandom_range(1, 6);
			h    = $urandom_range(1, 4);
			start_file(16'(w), 16'(h), 8'(bpp), 16'(ncol));
			add_random(ncol * 4 + (w * h * bpp + 7) / 8 + $urandom_range(0, 2));
			if (kind == 1) begin
				// broken file, the next one restarts it
				cut = $urandom_range(1, file_q.size() - 1);
				while (file_q.size() > cut) void'(file_q.pop_back());
			end
		end
		rand_sent += file_q.size();
		send_file();
	endtask

	initial begin
		int          nfile;
		logic [31:0] color;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_override(1'b1, 32'hFFFF_FFFF);
		// 1 bpp, full bytes of ones and zeros, trailing byte
		start_file(16'd8, 16'd2, 8'd1, 16'd2);
		file_q = {file_q, 8'h00, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78,
			8'hFF, 8'h00, 8'hAA};
		send_file();
		settle();
		set_override(1'b1, 32'h0000_0000);
		// 16 bpp: partial index stays buffered, then max index out of range
		start_file(16'd1, 16'd2, 8'd16, 16'd1);
		add_random(4);
		file_q = {file_q, 8'h00, 8'h00, 8'hFF, 8'hFF};
		send_file();
		start_file(16'd3, 16'd1, 8'd1, 16'd2);
		add_random(8);
		file_q = {file_q, 8'h5A, 8'h3C};
		send_file();
		// bad depths
		start_file(16'd2, 16'd2, 8'd0, 16'd1);
		add_random(2);
		send_file();
		start_file(16'd2, 16'd2, 8'(pid_pkg::MAX_BPP + 1), 16'd1);
		send_file();
		start_file(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
		add_random(2);
		send_file();
		// empty palette with override on: index zero is still black
		start_file(16'd2, 16'd1, 8'd1, 16'd0);
		file_q = {file_q, 8'h00};
		send_file();
		// empty images
		start_file(16'd0, 16'd5, 8'd4, 16'd1);
		add_random(6);
		send_file();
		start_file(16'd0, 16'd0, 8'd8, 16'd0);
		add_random(1);
		send_file();
		// restart inside header, inside palette and inside pixels
		file_q = {};
		add_random(3);
		send_file();
		start_file(16'd2, 16'd1, 8'd8, 16'd3);
		add_random(5);
		send_file();
		start_file(16'hFFFF, 16'hFFFF, 8'd8, 16'd1);
		add_random(7);
		send_file();
		start_file(16'd1, 16'd1, 8'd2, 16'hFFFF);
		add_random(6);
		send_file();

		nfile = 0;
		while (nfile < 3 || rand_sent < RAND_BYTES) begin
			if (nfile % 3 == 0) begin
				settle();
				case ($urandom_range(3))
					0: color = 32'h0000_0000;
					1: color = 32'hFFFF_FFFF;
					default: color = $urandom;
				endcase
				set_override(1'($urandom_range(1)), color);
			end
			calm = (nfile == 2);
			if (nfile == 1) begin
				// hold the output off while a long 1 bpp image streams in
				hold_asked++;
				start_file(16'd16, 16'd8, 8'd1, 16'd2);
				add_random(8 + 16);
				rand_sent += file_q.size();
				send_file();
			end else begin
				case ($urandom_range(9))
					0: random_file(0);
					1: random_file(1);
					default: random_file(2);
				endcase
			end
			nfile++;
		end
		calm = 0;

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

@@ files.f @@
rtl/core/pid_pkg.sv
rtl/core/pid_ram.sv
rtl/core/pid_ctrl.sv
rtl/core/pid_datapath.sv
rtl/core/palette_image_decoder_core.sv
verif/testbench.sv
